// ===== rtl/single_edit_variant_checker_core_assert.svh =====
// ----------------------------------------------------------------------------
// Single-edit variant checker assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef SINGLE_EDIT_VARIANT_CHECKER_CORE_ASSERT_SVH
`define SINGLE_EDIT_VARIANT_CHECKER_CORE_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define SEVC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define SEVC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/sevc_pkg.sv =====
// ----------------------------------------------------------------------------
// Single-edit variant checker package
// Field codes and the command and result types shared by the modules.
// ----------------------------------------------------------------------------
package sevc_pkg;

	localparam logic [1:0] MODE_SEED  = 2'd0;
	localparam logic [1:0] MODE_AMP   = 2'd1;
	localparam logic [1:0] MODE_CHECK = 2'd2;

	localparam logic [1:0] KIND_SUB = 2'd0;
	localparam logic [1:0] KIND_DEL = 2'd1;
	localparam logic [1:0] KIND_INS = 2'd2;

	localparam int IDX_W  = 10;
	localparam int POS_W  = 11;
	localparam int BASE_W = 2;

	typedef struct packed {
		logic [1:0]        variant_kind;
		logic [POS_W-1:0]  edit_position;
		logic [BASE_W-1:0] new_base;
		logic [POS_W-1:0]  seed_length;
		logic [POS_W-1:0]  amp_length;
	} chk_cmd_t;

	typedef struct packed {
		logic is_equal;
		logic bad_position;
	} chk_res_t;

endpackage

// ===== rtl/sevc_mem.sv =====
// ----------------------------------------------------------------------------
// Nucleotide store
// One write port and one registered read port.
// ----------------------------------------------------------------------------
module sevc_mem #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/sevc_walk.sv =====
// ----------------------------------------------------------------------------
// Edit walk sequencer
// Screens a check command, then walks the amplicon one position per cycle,
// comparing each base with the edited seed through one shared comparator.
// ----------------------------------------------------------------------------
module sevc_walk #(
	parameter int MAX_LEN = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  sevc_pkg::chk_cmd_t         cmd,
	output logic                       idle,
	output logic [$clog2(MAX_LEN)-1:0] seed_raddr,
	output logic [$clog2(MAX_LEN)-1:0] amp_raddr,
	input  logic [1:0]                 seed_rdata,
	input  logic [1:0]                 amp_rdata,
	output logic                       res_valid,
	input  logic                       res_take,
	output sevc_pkg::chk_res_t         res
);

	import sevc_pkg::*;

	localparam int AW = $clog2(MAX_LEN);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_WALK  = 4'b0010,
		ST_FLUSH = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t             state_q;
	logic [1:0]         kind_q;
	logic [POS_W-1:0]   pos_q;
	logic [BASE_W-1:0]  base_q;
	logic [POS_W-1:0]   alen_q;
	logic [POS_W-1:0]   i_q;
	logic               eq_q;
	logic               bad_q;
	logic               p_s1;
	logic               use_base_s1;

	logic               bad;
	logic               kind_ok;
	logic [POS_W:0]     want_len;
	logic               fits;
	logic               ok;
	logic [POS_W:0]     slen_x;
	logic [POS_W:0]     i_x;
	logic [POS_W:0]     seed_idx;
	logic               use_base;
	logic [BASE_W-1:0]  want_base;

	assign slen_x = {1'b0, cmd.seed_length};

	always_comb begin
		bad      = 1'b0;
		kind_ok  = 1'b1;
		want_len = slen_x;
		case (cmd.variant_kind)
			KIND_SUB: begin
				bad      = cmd.edit_position >= cmd.seed_length;
				want_len = slen_x;
			end
			KIND_DEL: begin
				bad      = cmd.edit_position >= cmd.seed_length;
				want_len = slen_x - 12'd1;
			end
			KIND_INS: begin
				bad      = cmd.edit_position > cmd.seed_length;
				want_len = slen_x + 12'd1;
			end
			default: begin
				kind_ok = 1'b0;
			end
		endcase
	end

	assign fits = (32'(cmd.seed_length) <= 32'(MAX_LEN)) &&
		(32'(cmd.amp_length) <= 32'(MAX_LEN));
	assign ok = kind_ok && !bad && ({1'b0, cmd.amp_length} == want_len) && fits;

	assign i_x = {1'b0, i_q};

	always_comb begin
		seed_idx = i_x;
		use_base = 1'b0;
		if (i_q >= pos_q) begin
			case (kind_q)
				KIND_SUB: begin
					use_base = (i_q == pos_q);
				end
				KIND_DEL: begin
					seed_idx = i_x + 12'd1;
				end
				KIND_INS: begin
					use_base = (i_q == pos_q);
					seed_idx = i_x - 12'd1;
				end
				default: begin
					seed_idx = i_x;
				end
			endcase
		end
	end

	assign seed_raddr = AW'(seed_idx);
	assign amp_raddr  = AW'(i_q);

	assign want_base = use_base_s1 ? base_q : seed_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			p_s1        <= 1'b0;
			use_base_s1 <= 1'b0;
			eq_q        <= 1'b0;
			bad_q       <= 1'b0;
			i_q         <= '0;
		end else begin
			p_s1        <= (state_q == ST_WALK);
			use_base_s1 <= use_base;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						bad_q <= bad;
						i_q   <= '0;
						if (ok && (cmd.amp_length != '0)) begin
							eq_q    <= 1'b1;
							state_q <= ST_WALK;
						end else begin
							eq_q    <= ok;
							state_q <= ST_DONE;
						end
					end
				end
				ST_WALK: begin
					i_q <= i_q + 11'd1;
					if (i_q == 11'(alen_q - 11'd1)) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (p_s1 && (amp_rdata != want_base)) begin
				eq_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && (state_q == ST_IDLE)) begin
			kind_q <= cmd.variant_kind;
			pos_q  <= cmd.edit_position;
			base_q <= cmd.new_base;
			alen_q <= cmd.amp_length;
		end
	end

	assign idle             = (state_q == ST_IDLE);
	assign res_valid        = (state_q == ST_DONE);
	assign res.is_equal     = eq_q;
	assign res.bad_position = bad_q;

endmodule

// ===== rtl/single_edit_variant_checker_core.sv =====
// ----------------------------------------------------------------------------
// Single-edit variant checker core
// Checks whether an amplicon equals a stored seed with one edit applied.
// ----------------------------------------------------------------------------
// The input channel (in_valid/in_ready) carries load beats and check beats.
// A load beat writes one base into the seed or amplicon store and gives no
// result. A check beat names a substitution, deletion or insertion and both
// lengths, and gives one result beat on the output channel (out_valid/out_ready)
// with is_equal and bad_position.
// A check walks the amplicon one position per cycle through the store read
// ports, then passes a flush state before its result is ready; when the lengths
// or position already decide it, the result is ready without a walk. in_ready
// stays low from the check beat until the result moves to the output register.
// A result waits in the output register while the receiver stalls; loads
// are still taken then, and a further check finishes its walk and waits.
// Reset clears the sequencer and the output valid flag; store contents are
// undefined until loaded.
// ----------------------------------------------------------------------------
module single_edit_variant_checker_core #(
	parameter int MAX_LEN = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [9:0]  load_index,
	input  logic [1:0]  load_base,
	input  logic [1:0]  variant_kind,
	input  logic [10:0] edit_position,
	input  logic [1:0]  new_base,
	input  logic [10:0] seed_length,
	input  logic [10:0] amp_length,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        is_equal,
	output logic        bad_position
);

	import sevc_pkg::*;

	localparam int AW = $clog2(MAX_LEN);

	logic           in_fire;
	logic           idx_ok;
	logic           seed_we;
	logic           amp_we;
	logic [AW-1:0]  waddr;
	logic [AW-1:0]  seed_raddr;
	logic [AW-1:0]  amp_raddr;
	logic [1:0]     seed_rdata;
	logic [1:0]     amp_rdata;
	logic           start;
	chk_cmd_t       cmd;
	logic           walk_idle;
	logic           res_valid;
	logic           res_take;
	chk_res_t       res;
	logic           out_valid_q;
	chk_res_t       out_q;

	assign in_ready = walk_idle;
	assign in_fire  = in_valid && in_ready;
	assign idx_ok   = 32'(load_index) < 32'(MAX_LEN);
	assign seed_we  = in_fire && (mode == MODE_SEED) && idx_ok;
	assign amp_we   = in_fire && (mode == MODE_AMP) && idx_ok;
	assign waddr    = AW'(load_index);
	assign start    = in_fire && (mode == MODE_CHECK);

	assign cmd.variant_kind  = variant_kind;
	assign cmd.edit_position = edit_position;
	assign cmd.new_base      = new_base;
	assign cmd.seed_length   = seed_length;
	assign cmd.amp_length    = amp_length;

	sevc_mem #(
		.DEPTH(MAX_LEN),
		.WIDTH(BASE_W)
	) u_seed_mem (
		.clk  (clk),
		.we   (seed_we),
		.waddr(waddr),
		.wdata(load_base),
		.raddr(seed_raddr),
		.rdata(seed_rdata)
	);

	sevc_mem #(
		.DEPTH(MAX_LEN),
		.WIDTH(BASE_W)
	) u_amp_mem (
		.clk  (clk),
		.we   (amp_we),
		.waddr(waddr),
		.wdata(load_base),
		.raddr(amp_raddr),
		.rdata(amp_rdata)
	);

	sevc_walk #(
		.MAX_LEN(MAX_LEN)
	) u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.idle      (walk_idle),
		.seed_raddr(seed_raddr),
		.amp_raddr (amp_raddr),
		.seed_rdata(seed_rdata),
		.amp_rdata (amp_rdata),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res)
	);

	assign res_take = res_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign is_equal     = out_q.is_equal;
	assign bad_position = out_q.bad_position;

endmodule

// ===== rtl/sevc_checker.sv =====
// ----------------------------------------------------------------------------
// Single-edit variant checker port assertions
// Checks beat ordering and result consistency on the top-level ports.
// ----------------------------------------------------------------------------
`include "single_edit_variant_checker_core_assert.svh"

module sevc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [1:0] mode,
	input logic       out_valid,
	input logic       out_ready,
	input logic       is_equal,
	input logic       bad_position
);

	import sevc_pkg::*;

	`SEVC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(is_equal) && $stable(bad_position), "output beat changed while stalled")
	`SEVC_ASSERT_NOW(a_bad_not_equal, out_valid && bad_position, !is_equal, "bad position reported as equal")
	`SEVC_ASSERT_NEXT(a_check_busy, in_valid && in_ready && (mode == MODE_CHECK), !in_ready, "input still ready after a check beat")
	`SEVC_ASSERT_NEXT(a_load_free, in_valid && in_ready && (mode != MODE_CHECK), in_ready, "load beat stalled the input")

endmodule

bind single_edit_variant_checker_core sevc_checker u_sevc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.mode        (mode),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.is_equal    (is_equal),
	.bad_position(bad_position)
);

// ===== verif/edit_verdict_checker.sv =====
// ----------------------------------------------------------------------------
// Edit verdict checker
// Watches both channels of the single-edit variant checker core. It mirrors
// the seed and amplicon stores from the load beats, predicts the verdict of
// every check beat and compares each result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module edit_verdict_checker #(
	parameter int MAX_LEN = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [9:0]  load_index,
	input  logic [1:0]  load_base,
	input  logic [1:0]  variant_kind,
	input  logic [10:0] edit_position,
	input  logic [1:0]  new_base,
	input  logic [10:0] seed_length,
	input  logic [10:0] amp_length,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        is_equal,
	input  logic        bad_position,
	output int          mismatches,
	output int          outstanding
);

	import sevc_pkg::*;

	logic [1:0] seed_mirror [MAX_LEN];
	logic [1:0] amp_mirror [MAX_LEN];
	chk_res_t   verdict_q [$];
	chk_res_t   oldest;
	int         errs = 0;

	initial begin
		mismatches = 0;
		outstanding = 0;
		foreach (seed_mirror[i]) begin
			seed_mirror[i] = '0;
			amp_mirror[i] = '0;
		end
	end

	function automatic chk_res_t predict_verdict(logic [1:0] kind, logic [10:0] pos_in,
			logic [1:0] nb, logic [10:0] slen_in, logic [10:0] alen_in);
		chk_res_t   res;
		int         pos;
		int         slen;
		int         alen;
		int         want_len;
		logic [1:0] want;
		res = '0;
		pos = int'(pos_in);
		slen = int'(slen_in);
		alen = int'(alen_in);
		if (kind == KIND_INS) begin
			res.bad_position = (pos > slen);
			want_len = slen + 1;
		end else if (kind == KIND_SUB || kind == KIND_DEL) begin
			res.bad_position = (pos >= slen);
			want_len = (kind == KIND_SUB) ? slen : slen - 1;
		end else begin
			return res;
		end
		if (!res.bad_position && alen == want_len &&
				slen <= MAX_LEN && alen <= MAX_LEN) begin
			res.is_equal = 1'b1;
			for (int i = 0; i < alen; i++) begin
				if (i < pos)
					want = seed_mirror[i];
				else if (kind == KIND_SUB)
					want = (i == pos) ? nb : seed_mirror[i];
				else if (kind == KIND_DEL)
					want = seed_mirror[i + 1];
				else
					want = (i == pos) ? nb : seed_mirror[i - 1];
				if (amp_mirror[i] != want)
					res.is_equal = 1'b0;
			end
		end
		return res;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (verdict_q.size() == 0) begin
					errs++;
					$display("%0t: result beat with none expected, actual %0b %0b",
						$time, is_equal, bad_position);
				end else begin
					oldest = verdict_q.pop_front();
					if (is_equal !== oldest.is_equal) begin
						errs++;
						$display("%0t: is_equal expected %0b actual %0b",
							$time, oldest.is_equal, is_equal);
					end
					if (bad_position !== oldest.bad_position) begin
						errs++;
						$display("%0t: bad_position expected %0b actual %0b",
							$time, oldest.bad_position, bad_position);
					end
				end
			end
			if (in_valid && in_ready) begin
				case (mode)
					MODE_SEED: begin
						if (int'(load_index) < MAX_LEN)
							seed_mirror[load_index] = load_base;
					end
					MODE_AMP: begin
						if (int'(load_index) < MAX_LEN)
							amp_mirror[load_index] = load_base;
					end
					MODE_CHECK: begin
						verdict_q.push_back(predict_verdict(variant_kind, edit_position,
							new_base, seed_length, amp_length));
					end
					default: begin
					end
				endcase
			end
		end
		mismatches <= errs;
		outstanding <= verdict_q.size();
	end

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// Single-edit variant checker testbench
// Loads seeds and amplicons, issues substitution, deletion and insertion
// checks (mostly well-formed edits with random content, some flawed, plus
// noise), with random gaps on both channels, and leaves the comparison of
// every verdict to the edit verdict checker.
// ----------------------------------------------------------------------------
module tb_top;
	import sevc_pkg::*;

	localparam int MAX_LEN      = 1024;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int RANDOM_BEATS = 850;
	localparam logic [1:0] MODE_NONE = 2'd3;
	localparam logic [1:0] KIND_NONE = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic [1:0]  mode = '0;
	logic [9:0]  load_index = '0;
	logic [1:0]  load_base = '0;
	logic [1:0]  variant_kind = '0;
	logic [10:0] edit_position = '0;
	logic [1:0]  new_base = '0;
	logic [10:0] seed_length = '0;
	logic [10:0] amp_length = '0;
	logic        out_ready = 1'b0;
	logic        in_ready;
	logic        out_valid;
	logic        is_equal;
	logic        bad_position;
	int          mismatches;
	int          outstanding;

	bit          calm = 1'b0;
	int          beats_sent = 0;
	int          checks_sent = 0;
	int          cycles = 0;
	logic [1:0]  seed_img [MAX_LEN];
	bit          seed_wr [MAX_LEN];
	bit          amp_wr [MAX_LEN];
	logic [1:0]  edited_amp [$];

	single_edit_variant_checker_core #(
		.MAX_LEN(MAX_LEN)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.load_index(load_index),
		.load_base(load_base),
		.variant_kind(variant_kind),
		.edit_position(edit_position),
		.new_base(new_base),
		.seed_length(seed_length),
		.amp_length(amp_length),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.is_equal(is_equal),
		.bad_position(bad_position)
	);

	edit_verdict_checker #(
		.MAX_LEN(MAX_LEN)
	) u_chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.load_index(load_index),
		.load_base(load_base),
		.variant_kind(variant_kind),
		.edit_position(edit_position),
		.new_base(new_base),
		.seed_length(seed_length),
		.amp_length(amp_length),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.is_equal(is_equal),
		.bad_position(bad_position),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin : watchdog
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("single_edit_variant_checker_core regression: fail");
		$finish;
	end

	initial begin : result_side
		int stall;
		forever begin
			stall = calm ? 0 : int'($urandom_range(0, 9));
			if (stall != 0) begin
				out_ready <= 1'b0;
				@(posedge clk);
				while (!out_valid)
					@(posedge clk);
				repeat (stall - 1) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic push_beat(input logic [1:0] m, input logic [9:0] idx, input logic [1:0] lb,
			input logic [1:0] k, input logic [10:0] p, input logic [1:0] nb,
			input logic [10:0] sl, input logic [10:0] al);
		int gap;
		gap = calm ? 0 : int'($urandom_range(0, 9));
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		load_index <= idx;
		load_base <= lb;
		variant_kind <= k;
		edit_position <= p;
		new_base <= nb;
		seed_length <= sl;
		amp_length <= al;
		do @(posedge clk); while (!in_ready);
		if (m != MODE_NONE)
			beats_sent++;
		if (m == MODE_CHECK)
			checks_sent++;
	endtask

	task automatic put_seed(input int idx, input int b);
		push_beat(MODE_SEED, 10'(idx), 2'(b), 2'($urandom), 11'($urandom), 2'($urandom),
			11'($urandom), 11'($urandom));
		seed_img[idx] = 2'(b);
		seed_wr[idx] = 1'b1;
	endtask

	task automatic put_amp(input int idx, input int b);
		push_beat(MODE_AMP, 10'(idx), 2'(b), 2'($urandom), 11'($urandom), 2'($urandom),
			11'($urandom), 11'($urandom));
		amp_wr[idx] = 1'b1;
	endtask

	// Every entry a check might read is loaded first, so no unwritten entry is walked.
	task automatic run_check(input int k, input int p, input int nb, input int sl, input int al);
		int top;
		int diff;
		diff = sl - al;
		if (sl <= MAX_LEN && al <= MAX_LEN &&
				((sl <= 64 && al <= 64) || (diff >= -1 && diff <= 1))) begin
			top = ((sl > al) ? sl : al) + 1;
			if (top > MAX_LEN - 1)
				top = MAX_LEN - 1;
			for (int i = 0; i <= top; i++) begin
				if (!seed_wr[i])
					put_seed(i, int'($urandom_range(0, 3)));
				if (!amp_wr[i])
					put_amp(i, int'($urandom_range(0, 3)));
			end
		end
		push_beat(MODE_CHECK, 10'($urandom), 2'($urandom), 2'(k), 11'(p), 2'(nb), 11'(sl),
			11'(al));
	endtask

	task automatic build_case(input int sl);
		int         k;
		int         p;
		int         al;
		int         j;
		int         flaw;
		logic [1:0] nb;
		logic [1:0] cur;
		bit         runs;
		k = (sl == 0) ? int'(KIND_INS) : int'($urandom_range(0, 2));
		if (k == int'(KIND_INS) && sl >= MAX_LEN)
			k = int'($urandom_range(0, 1));
		p = (k == int'(KIND_INS)) ? int'($urandom_range(0, sl)) : int'($urandom_range(0, sl - 1));
		nb = 2'($urandom);
		runs = ($urandom_range(0, 3) == 0);
		cur = 2'($urandom);
		for (int i = 0; i < sl; i++) begin
			if (!runs || $urandom_range(0, 4) == 0)
				cur = 2'($urandom);
			put_seed(i, int'(cur));
		end
		edited_amp.delete();
		for (int i = 0; i < sl; i++) begin
			if (i == p && k == int'(KIND_SUB)) begin
				edited_amp.push_back(nb);
			end else if (i == p && k == int'(KIND_INS)) begin
				edited_amp.push_back(nb);
				edited_amp.push_back(seed_img[i]);
			end else if (i != p || k != int'(KIND_DEL)) begin
				edited_amp.push_back(seed_img[i]);
			end
		end
		if (k == int'(KIND_INS) && p == sl)
			edited_amp.push_back(nb);
		al = edited_amp.size();
		flaw = int'($urandom_range(0, 9));
		if ((flaw == 6 || flaw == 7) && al > 0) begin
			j = int'($urandom_range(0, al - 1));
			edited_amp[j] = edited_amp[j] ^ 2'($urandom_range(1, 3));
		end else if (flaw == 8) begin
			al = (al == 0 || $urandom_range(0, 1) == 1) ? al + 1 : al - 1;
		end else if (flaw == 9) begin
			p = p + 1;
		end
		for (int i = 0; i < edited_amp.size(); i++)
			put_amp(i, int'(edited_amp[i]));
		run_check(k, p, int'(nb), sl, al);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	initial begin : stimulus
		int pick;
		int rounds;
		int s;
		int a;
		int p;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 6; i++)
			put_seed(i, i % 4);
		for (int i = 0; i < 7; i++)
			put_amp(i, (i == 2) ? 3 : i % 4);
		run_check(int'(KIND_SUB), 2, 3, 6, 6);
		run_check(int'(KIND_SUB), 0, 0, 0, 0);
		run_check(int'(KIND_INS), 0, 0, 0, 1);
		run_check(int'(KIND_DEL), 0, 0, 1, 0);
		run_check(int'(KIND_DEL), 1, 0, 1, 0);
		run_check(int'(KIND_INS), 5, 1, 5, 6);
		run_check(int'(KIND_INS), 6, 1, 5, 6);
		run_check(int'(KIND_INS), 2, 3, 3, 4);
		run_check(int'(KIND_DEL), 2, 0, 5, 4);
		run_check(int'(KIND_SUB), 3, 3, 4, 5);
		run_check(int'(KIND_NONE), 0, 0, 4, 4);
		push_beat(MODE_NONE, '1, '1, '1, '1, '1, '1, '1);
		run_check(int'(KIND_SUB), 2047, 3, 2047, 2047);
		run_check(int'(KIND_SUB), 0, 0, 1025, 1025);
		run_check(int'(KIND_INS), 1024, 2, 1024, 1025);
		run_check(int'(KIND_DEL), 0, 1, 2047, 0);
		settle();

		beats_sent = 0;
		checks_sent = 0;
		rounds = 0;
		while (beats_sent < RANDOM_BEATS || checks_sent < 60) begin
			pick = int'($urandom_range(0, 99));
			if (pick < 55) begin
				if ($urandom_range(0, 49) == 0)
					build_case(int'($urandom_range(100, 200)));
				else if ($urandom_range(0, 7) == 0)
					build_case(int'($urandom_range(0, 40)));
				else
					build_case(int'($urandom_range(1, 10)));
			end else if (pick < 80) begin
				if ($urandom_range(0, 9) < 7) begin
					s = int'($urandom_range(0, 12));
					a = s + int'($urandom_range(0, 2)) - 1;
					if (a < 0)
						a = 0;
					p = int'($urandom_range(0, s + 1));
				end else begin
					s = int'(11'($urandom));
					a = int'(11'($urandom));
					p = int'(11'($urandom));
				end
				run_check(int'($urandom_range(0, 3)), p, int'($urandom_range(0, 3)), s, a);
			end else if (pick < 92) begin
				s = int'(10'($urandom));
				if ($urandom_range(0, 1) == 0)
					put_seed(s, int'($urandom_range(0, 3)));
				else
					put_amp(s, int'($urandom_range(0, 3)));
			end else begin
				push_beat(MODE_NONE, 10'($urandom), 2'($urandom), 2'($urandom), 11'($urandom),
					2'($urandom), 11'($urandom), 11'($urandom));
			end
			rounds++;
			if (rounds % 25 == 0) begin
				calm = ~calm;
				settle();
			end
		end

		settle();
		repeat (MAX_LEN + 64) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("single_edit_variant_checker_core regression: pass");
		else
			$display("single_edit_variant_checker_core regression: fail");
		$finish;
	end

endmodule
